// ===== sv/itb_pkg.sv =====
`default_nettype none
package itb_pkg;

   // fixed field widths
   localparam int CMD_W   = 2;
   localparam int ROW_W   = 7;
   localparam int COL_W   = 8;
   localparam int PIX_W   = 8;
   localparam int THR_W   = 8;
   localparam int CSR_A_W = 5;
   localparam int CSR_D_W = 32;

   // default geometry
   localparam int ROWS_DEF     = 120;
   localparam int COLS_DEF     = 188;
   localparam int MAX_ITER_DEF = 16;

   // register reset values
   localparam logic [7:0] SLEW_RST   = 8'd15;
   localparam logic [7:0] TMIN_RST   = 8'd5;
   localparam logic [7:0] TMAX_RST   = 8'd250;
   localparam logic [7:0] TOL_RST    = 8'd2;
   localparam logic [6:0] RFIRST_RST = 7'd20;
   localparam logic [6:0] REND_RST   = 7'd50;
   localparam logic [6:0] MARGIN_RST = 7'd12;

   typedef enum logic [CMD_W-1:0] {
      CMD_STORE    = 2'd0,
      CMD_COMPUTE  = 2'd1,
      CMD_CLASSIFY = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_SLEW   = 3'd0,
      REG_TMIN   = 3'd1,
      REG_TMAX   = 3'd2,
      REG_TOL    = 3'd3,
      REG_RFIRST = 3'd4,
      REG_REND   = 3'd5,
      REG_MARGIN = 3'd6,
      REG_NONE   = 3'd7
   } reg_idx_type;

endpackage
`default_nettype wire

// ===== sv/itb_req_if.sv =====
`default_nettype none
interface itb_req_if;
   logic                          valid;
   logic                          ready;
   logic [itb_pkg::CMD_W-1:0]     command;
   logic [itb_pkg::ROW_W-1:0]     row;
   logic [itb_pkg::COL_W-1:0]     col;
   logic [itb_pkg::PIX_W-1:0]     pixel;

   modport source (output valid, command, row, col, pixel, input ready);
   modport sink   (input valid, command, row, col, pixel, output ready);
endinterface
`default_nettype wire

// ===== sv/itb_rsp_if.sv =====
`default_nettype none
interface itb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [itb_pkg::THR_W-1:0]     threshold;
   logic                          is_white;
   logic                          converged;

   modport source (output valid, threshold, is_white, converged, input ready);
   modport sink   (input valid, threshold, is_white, converged, output ready);
endinterface
`default_nettype wire

// ===== sv/iterative_threshold_binarizer_unit.sv =====
`default_nettype none
// Isodata threshold binarizer with an on-chip grey frame store.
// req_ch carries items (store pixel, compute threshold, classify pixel);
// rsp_ch returns exactly one result per item; the csr_ port is APB-style,
// registers at byte address 4*i, pready always high.
// Steps from accept to result valid:
//   store: result registered directly; classify: registered frame store
//   read, then result register; compute: a min/max scan, then per pass a
//   class scan, 2 x 8 divider steps and an update, then a finish step, all
//   over the pixels of the search region; at most MAX_ITER passes. A pass
//   with an empty class skips the divider and goes to the finish step, as does an empty region.
//   The scan reads one pixel per cycle from the single frame store port and
//   the class means come from one shared 8-step restoring divider.
// Store items sustain one per cycle while the receiver takes results; the
// block takes a new item only when idle and the result register is free or
// being taken in the same cycle. A stalled receiver holds the result and
// blocks further input.
// Reset (synchronous) clears the kept threshold to zero, returns the
// registers to their defaults and drops any pending result; frame store
// contents are not cleared and are undefined until written.
module iterative_threshold_binarizer_unit #(
   parameter int ROWS     = itb_pkg::ROWS_DEF,
   parameter int COLS     = itb_pkg::COLS_DEF,
   parameter int MAX_ITER = itb_pkg::MAX_ITER_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   itb_req_if.sink                            req_ch,
   itb_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [itb_pkg::CSR_A_W-1:0]   csr_paddr,
   input  wire logic [itb_pkg::CSR_D_W-1:0]   csr_pwdata,
   output logic      [itb_pkg::CSR_D_W-1:0]   csr_prdata,
   output logic                               csr_pready
);

   localparam int NPIX   = ROWS * COLS;
   localparam int ADDR_W = $clog2(NPIX);
   localparam int C_W    = $clog2(COLS + 1);
   localparam int CNT_W  = $clog2(NPIX + 1);
   localparam int SUM_W  = $clog2(NPIX * 255 + 1);
   localparam int CMP_W  = (CNT_W + 8 > SUM_W) ? CNT_W + 8 : SUM_W;
   localparam int IT_W   = $clog2(MAX_ITER + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_MINMAX, ST_CLASS, ST_DIV0, ST_DIV1, ST_UPDATE, ST_FINISH
   } state_type;

   // configuration registers
   logic [7:0] slew_ff, tmin_ff, tmax_ff, tol_ff;
   logic [6:0] rfirst_ff, rend_ff, margin_ff;
   logic       csr_wr;
   itb_pkg::reg_idx_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = itb_pkg::reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         slew_ff   <= itb_pkg::SLEW_RST;
         tmin_ff   <= itb_pkg::TMIN_RST;
         tmax_ff   <= itb_pkg::TMAX_RST;
         tol_ff    <= itb_pkg::TOL_RST;
         rfirst_ff <= itb_pkg::RFIRST_RST;
         rend_ff   <= itb_pkg::REND_RST;
         margin_ff <= itb_pkg::MARGIN_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            itb_pkg::REG_SLEW:   slew_ff   <= csr_pwdata[7:0];
            itb_pkg::REG_TMIN:   tmin_ff   <= csr_pwdata[7:0];
            itb_pkg::REG_TMAX:   tmax_ff   <= csr_pwdata[7:0];
            itb_pkg::REG_TOL:    tol_ff    <= csr_pwdata[7:0];
            itb_pkg::REG_RFIRST: rfirst_ff <= csr_pwdata[6:0];
            itb_pkg::REG_REND:   rend_ff   <= csr_pwdata[6:0];
            itb_pkg::REG_MARGIN: margin_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         itb_pkg::REG_SLEW:   csr_prdata[7:0] = slew_ff;
         itb_pkg::REG_TMIN:   csr_prdata[7:0] = tmin_ff;
         itb_pkg::REG_TMAX:   csr_prdata[7:0] = tmax_ff;
         itb_pkg::REG_TOL:    csr_prdata[7:0] = tol_ff;
         itb_pkg::REG_RFIRST: csr_prdata[6:0] = rfirst_ff;
         itb_pkg::REG_REND:   csr_prdata[6:0] = rend_ff;
         itb_pkg::REG_MARGIN: csr_prdata[6:0] = margin_ff;
         default: ;
      endcase
   end

   // region bounds
   logic [6:0]     r1;
   logic [C_W-1:0] c0, c1;
   logic           region_empty;

   always_comb begin
      r1 = (int'(rend_ff) < ROWS) ? rend_ff : 7'(ROWS);
      c0 = C_W'(margin_ff);
      c1 = (int'(margin_ff) < COLS) ? C_W'(COLS - int'(margin_ff)) : '0;
      region_empty = (rfirst_ff >= r1) || (c0 >= c1);
   end

   // frame store
   logic [7:0]        mem [NPIX];
   logic              mem_we;
   logic [ADDR_W-1:0] req_addr, rd_addr;
   logic [7:0]        rd_data_ff;
   logic              req_inside;

   assign req_addr   = ADDR_W'(int'(req_ch.row) * COLS + int'(req_ch.col));
   assign req_inside = (int'(req_ch.row) < ROWS) && (int'(req_ch.col) < COLS);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_addr] <= req_ch.pixel;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sequencer state
   state_type         state_ff, state_in;
   logic [6:0]        r_ff, r_in;
   logic [C_W-1:0]    c_ff, c_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic              issue_ff, issue_in, pend_ff, pend_in;
   logic [7:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic [8:0]        est_ff, est_in;
   logic [SUM_W-1:0]  s0_ff, s0_in, s1_ff, s1_in, rem_ff, rem_in;
   logic [CNT_W-1:0]  n0_ff, n0_in, n1_ff, n1_in;
   logic [IT_W-1:0]   iter_ff, iter_in;
   logic              conv_ff, conv_in, inside_ff, inside_in;
   logic [7:0]        prev_ff, prev_in, kept_ff, kept_in, raw_ff, raw_in;
   logic [7:0]        q_ff, q_in, m0_ff, m0_in;
   logic [2:0]        dstep_ff, dstep_in;
   logic              rsp_valid_ff, rsp_valid_in, white_ff, white_in, rconv_ff, rconv_in;
   logic [7:0]        rthr_ff, rthr_in;

   logic              req_ready, accept, scan_start;
   logic [CNT_W-1:0]  div_d;
   logic [CMP_W-1:0]  trial, rem_ext;
   logic [8:0]        next_est, diff, lim_hi, t;
   logic              again;
   logic [8:0]        sum_lh;

   assign req_ready    = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   always_comb begin
      state_in = state_ff; r_in = r_ff; c_in = c_ff; base_in = base_ff;
      issue_in = issue_ff; pend_in = pend_ff; lo_in = lo_ff; hi_in = hi_ff;
      est_in = est_ff; s0_in = s0_ff; s1_in = s1_ff; rem_in = rem_ff;
      n0_in = n0_ff; n1_in = n1_ff; iter_in = iter_ff; conv_in = conv_ff;
      inside_in = inside_ff; prev_in = prev_ff; kept_in = kept_ff; raw_in = raw_ff;
      q_in = q_ff; m0_in = m0_ff; dstep_in = dstep_ff;
      rsp_valid_in = rsp_valid_ff; white_in = white_ff; rconv_in = rconv_ff;
      rthr_in = rthr_ff;
      mem_we = 1'b0; scan_start = 1'b0;
      rd_addr = base_ff + ADDR_W'(c_ff);
      sum_lh = 9'(lo_ff) + 9'(hi_ff);
      next_est = 9'(m0_ff) + 9'(q_ff);
      diff = (next_est > est_ff) ? next_est - est_ff : est_ff - next_est;
      again = 1'b0;
      lim_hi = 9'(prev_ff) + 9'(slew_ff);
      t = 9'(raw_ff);
      div_d = (state_ff == ST_DIV0) ? n0_ff : n1_ff;
      trial = CMP_W'(div_d) << dstep_ff;
      rem_ext = CMP_W'(rem_ff);

      // result register drains on transfer
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = req_addr;
            if (accept) begin
               unique case (itb_pkg::cmd_type'(req_ch.command))
                  itb_pkg::CMD_STORE: begin
                     mem_we = req_inside;
                     rsp_valid_in = 1'b1; rthr_in = kept_ff;
                     white_in = 1'b0; rconv_in = 1'b0;
                  end
                  itb_pkg::CMD_CLASSIFY: begin
                     inside_in = req_inside;
                     state_in = ST_READ;
                  end
                  itb_pkg::CMD_COMPUTE: begin
                     prev_in = kept_ff;
                     if (region_empty) begin
                        raw_in = kept_ff; conv_in = 1'b0;
                        state_in = ST_FINISH;
                     end else begin
                        scan_start = 1'b1;
                        lo_in = 8'hff; hi_in = 8'h00;
                        state_in = ST_MINMAX;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1; rthr_in = kept_ff;
                     white_in = 1'b0; rconv_in = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1; rthr_in = kept_ff; rconv_in = 1'b0;
            white_in = inside_ff && (rd_data_ff >= kept_ff);
            state_in = ST_IDLE;
         end
         ST_MINMAX, ST_CLASS: begin
            // address walk, one pixel per cycle
            pend_in = issue_ff;
            if (issue_ff) begin
               if (c_ff == c1 - C_W'(1)) begin
                  c_in = c0; r_in = r_ff + 7'd1;
                  base_in = base_ff + ADDR_W'(COLS);
                  if (r_ff == r1 - 7'd1) begin
                     issue_in = 1'b0;
                  end
               end else begin
                  c_in = c_ff + C_W'(1);
               end
            end
            // accumulate the pixel read last cycle
            if (pend_ff) begin
               if (state_ff == ST_MINMAX) begin
                  if (rd_data_ff < lo_ff) lo_in = rd_data_ff;
                  if (rd_data_ff > hi_ff) hi_in = rd_data_ff;
               end else if ({rd_data_ff, 1'b0} < est_ff) begin
                  s0_in = s0_ff + SUM_W'(rd_data_ff); n0_in = n0_ff + CNT_W'(1);
               end else begin
                  s1_in = s1_ff + SUM_W'(rd_data_ff); n1_in = n1_ff + CNT_W'(1);
               end
            end
            if (!issue_ff && !pend_ff) begin
               if (state_ff == ST_MINMAX) begin
                  est_in = {sum_lh[8:1], 1'b0};
                  conv_in = 1'b1; iter_in = '0;
                  scan_start = 1'b1; state_in = ST_CLASS;
               end else if (n0_ff == '0 || n1_ff == '0) begin
                  conv_in = 1'b0; raw_in = est_ff[8:1];
                  state_in = ST_FINISH;
               end else begin
                  rem_in = s0_ff; q_in = '0; dstep_in = 3'd7;
                  state_in = ST_DIV0;
               end
            end
         end
         ST_DIV0, ST_DIV1: begin
            // one restoring step, quotient fits eight bits
            if (rem_ext >= trial) begin
               rem_in = SUM_W'(rem_ext - trial);
               q_in[dstep_ff] = 1'b1;
            end
            if (dstep_ff == 3'd0) begin
               if (state_ff == ST_DIV0) begin
                  m0_in = q_in; rem_in = s1_ff; q_in = '0;
                  dstep_in = 3'd7; state_in = ST_DIV1;
               end else begin
                  state_in = ST_UPDATE;
               end
            end else begin
               dstep_in = dstep_ff - 3'd1;
            end
         end
         ST_UPDATE: begin
            again = diff > {tol_ff, 1'b0};
            est_in = next_est;
            raw_in = next_est[8:1];
            if (next_est[8:1] > tmax_ff || next_est[8:1] < tmin_ff) begin
               again = 1'b0;
            end
            iter_in = iter_ff + IT_W'(1);
            if (!again) begin
               state_in = ST_FINISH;
            end else if (int'(iter_ff) + 1 >= MAX_ITER) begin
               conv_in = 1'b0; state_in = ST_FINISH;
            end else begin
               scan_start = 1'b1; state_in = ST_CLASS;
            end
         end
         ST_FINISH: begin
            // slew limit then clamp
            if (t > lim_hi) begin
               t = lim_hi;
            end else if (prev_ff > slew_ff && t < 9'(prev_ff - slew_ff)) begin
               t = 9'(prev_ff - slew_ff);
            end
            if (t > 9'(tmax_ff)) begin
               t = 9'(tmax_ff);
            end else if (t < 9'(tmin_ff)) begin
               t = 9'(tmin_ff);
            end
            kept_in = t[7:0];
            rsp_valid_in = 1'b1; rthr_in = t[7:0];
            white_in = 1'b0; rconv_in = conv_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // begin a region walk
      if (scan_start) begin
         r_in = rfirst_ff; c_in = c0;
         base_in = ADDR_W'(int'(rfirst_ff) * COLS);
         issue_in = 1'b1; pend_in = 1'b0;
         s0_in = '0; s1_in = '0; n0_in = '0; n1_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= 1'b0;
         pend_ff <= 1'b0;
         kept_ff <= '0;
         prev_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         pend_ff <= pend_in;
         kept_ff <= kept_in;
         prev_ff <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff <= r_in; c_ff <= c_in; base_ff <= base_in;
      lo_ff <= lo_in; hi_ff <= hi_in; est_ff <= est_in;
      s0_ff <= s0_in; s1_ff <= s1_in; rem_ff <= rem_in;
      n0_ff <= n0_in; n1_ff <= n1_in; iter_ff <= iter_in;
      conv_ff <= conv_in; inside_ff <= inside_in; raw_ff <= raw_in;
      q_ff <= q_in; m0_ff <= m0_in; dstep_ff <= dstep_in;
      white_ff <= white_in; rconv_ff <= rconv_in; rthr_ff <= rthr_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.threshold = rthr_ff;
   assign rsp_ch.is_white  = white_ff;
   assign rsp_ch.converged = rconv_ff;

endmodule
`default_nettype wire
